FILE: design/bttalu_pkg.sv
// package for the balanced-ternary tryte alu
// holds the operation codes, stage payload types and small constant tables
// no dependencies
package bttalu_pkg;

    localparam int unsigned FieldWidth = 10;
    localparam int unsigned OpWidth    = 3;
    localparam int unsigned ShiftWidth = 3;

    // six trits weighted 243, 81, 27, 9, 3, 1
    localparam int unsigned TryteMod = 729;
    localparam int unsigned TryteMax = 364;

    // offset that lifts any raw result (magnitude up to 364 * 364) to non-negative
    localparam int unsigned LiftCount = 182;
    localparam int unsigned WrapWidth = 19;

    // reciprocal of 729 scaled by 2**ModShift, rounded up
    localparam int unsigned ModShift  = 28;
    localparam int unsigned ModRecip  = 368225;
    localparam int unsigned QuotWidth = 9;

    // reciprocal scale for the right-shift divide
    localparam int unsigned DivShift = 20;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_SHL = 3'd4,
        OP_SHR = 3'd5,
        OP_CMP = 3'd6
    } op_t;

    typedef logic signed [FieldWidth-1:0] tryte_t;

    // after operand wrap
    typedef struct packed {
        op_t                   op;
        tryte_t                a;
        tryte_t                b;
        logic [ShiftWidth-1:0] k;
    } opnd_t;

    // after the product stage
    typedef struct packed {
        op_t                   op;
        logic signed [10:0]    lin;
        logic signed [19:0]    prod_ab;
        logic signed [17:0]    prod_shl;
        logic [31:0]           prod_shr;
    } prod_t;

    typedef logic [WrapWidth-1:0] lifted_t;

    // 3**k, zero for shifts of six or more
    function automatic logic [7:0] pow3(input logic [ShiftWidth-1:0] k);
        logic [7:0] p;
        case (k)
            3'd0:    p = 8'd1;
            3'd1:    p = 8'd3;
            3'd2:    p = 8'd9;
            3'd3:    p = 8'd27;
            3'd4:    p = 8'd81;
            3'd5:    p = 8'd243;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    // (3**k - 1) / 2, the rounding bias for dropping k trits
    function automatic logic [6:0] half3(input logic [ShiftWidth-1:0] k);
        logic [6:0] h;
        case (k)
            3'd0:    h = 7'd0;
            3'd1:    h = 7'd1;
            3'd2:    h = 7'd4;
            3'd3:    h = 7'd13;
            3'd4:    h = 7'd40;
            3'd5:    h = 7'd121;
            default: h = 7'd0;
        endcase
        return h;
    endfunction

    // ceil(2**20 / 3**k), zero for shifts of six or more
    function automatic logic [20:0] recip3(input logic [ShiftWidth-1:0] k);
        logic [20:0] m;
        case (k)
            3'd0:    m = 21'd1048576;
            3'd1:    m = 21'd349526;
            3'd2:    m = 21'd116509;
            3'd3:    m = 21'd38837;
            3'd4:    m = 21'd12946;
            3'd5:    m = 21'd4316;
            default: m = 21'd0;
        endcase
        return m;
    endfunction

    // 729 / 3**k, removes the divide offset again
    function automatic logic [9:0] base3(input logic [ShiftWidth-1:0] k);
        logic [9:0] b;
        case (k)
            3'd0:    b = 10'd729;
            3'd1:    b = 10'd243;
            3'd2:    b = 10'd81;
            3'd3:    b = 10'd27;
            3'd4:    b = 10'd9;
            3'd5:    b = 10'd3;
            default: b = 10'd0;
        endcase
        return b;
    endfunction

    // fold a 10-bit field into -364..364
    function automatic tryte_t wrap_field(input tryte_t v);
        logic signed [10:0] x;
        x = {v[FieldWidth-1], v};
        if (x > 11'sd364)
        begin
            x = x - 11'sd729;
        end
        else if (x < -11'sd364)
        begin
            x = x + 11'sd729;
        end
        return x[FieldWidth-1:0];
    endfunction

endpackage

FILE: design/bttalu_in_if.sv
// request channel of the tryte alu
// depends on bttalu_pkg
interface bttalu_in_if
    import bttalu_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OpWidth-1:0]     op;
    logic [FieldWidth-1:0]  operand_a;
    logic [FieldWidth-1:0]  operand_b;
    logic [ShiftWidth-1:0]  shift_amount;

    modport source (
        output valid,
        output op,
        output operand_a,
        output operand_b,
        output shift_amount,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  operand_a,
        input  operand_b,
        input  shift_amount,
        output ready
    );
endinterface

FILE: design/bttalu_out_if.sv
// result channel of the tryte alu
// depends on bttalu_pkg
interface bttalu_out_if
    import bttalu_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FieldWidth-1:0]  result_value;

    modport source (
        output valid,
        output result_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_value,
        output ready
    );
endinterface

FILE: design/bttalu_operand_stage.sv
// stage 1: takes the request and folds both operands into the tryte range
// depends on bttalu_pkg and bttalu_in_if
module bttalu_operand_stage
    import bttalu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    bttalu_in_if.sink       req,
    output logic            out_valid,
    input  logic            out_ready,
    output opnd_t           out_data
);
    logic  vld_reg;
    logic  vld_next;
    opnd_t data_reg;
    logic  adv;

    assign adv       = !vld_reg || out_ready;
    assign req.ready = adv;
    assign vld_next  = adv ? req.valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && req.valid)
        begin
            data_reg.op <= op_t'(req.op);
            data_reg.a  <= wrap_field(tryte_t'(req.operand_a));
            data_reg.b  <= wrap_field(tryte_t'(req.operand_b));
            data_reg.k  <= req.shift_amount;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;
endmodule

FILE: design/bttalu_op_unit.sv
// stages 2 and 3: products and linear ops, then select and lift to non-negative
// depends on bttalu_pkg
module bttalu_op_unit
    import bttalu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  opnd_t    in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lifted_t  out_data
);
    logic                s2_vld_reg;
    logic                s2_vld_next;
    prod_t               s2_reg;
    logic [ShiftWidth-1:0] s2_k_reg;
    logic                s2_adv;

    logic                s3_vld_reg;
    logic                s3_vld_next;
    lifted_t             s3_reg;
    logic                s3_adv;

    logic signed [10:0]  lin;
    logic signed [11:0]  div_sum;
    logic [10:0]         div_num;
    logic [11:0]         shr_quot;
    logic signed [19:0]  raw;
    logic signed [19:0]  lifted;

    assign s3_adv      = !s3_vld_reg || out_ready;
    assign s2_adv      = !s2_vld_reg || s3_adv;
    assign in_ready    = s2_adv;
    assign s2_vld_next = s2_adv ? in_valid : s2_vld_reg;
    assign s3_vld_next = s3_adv ? s2_vld_reg : s3_vld_reg;

    // add, subtract, negate and compare fit in 11 bits
    always_comb
    begin
        case (in_data.op)
            OP_ADD:  lin = {in_data.a[9], in_data.a} + {in_data.b[9], in_data.b};
            OP_SUB:  lin = {in_data.a[9], in_data.a} - {in_data.b[9], in_data.b};
            OP_NEG:  lin = -{in_data.a[9], in_data.a};
            OP_CMP:
            begin
                if (in_data.a < in_data.b)
                begin
                    lin = -11'sd1;
                end
                else if (in_data.a > in_data.b)
                begin
                    lin = 11'sd1;
                end
                else
                begin
                    lin = 11'sd0;
                end
            end
            default: lin = 11'sd0;
        endcase
    end

    // round-to-nearest divide by 3**k: bias, offset by 729 to stay positive
    assign div_sum = {{2{in_data.a[9]}}, in_data.a}
                   + $signed({5'd0, half3(in_data.k)}) + 12'sd729;
    assign div_num = div_sum[10:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
        end
    end

    // shift tables give zero for six or more trits, which clears the word
    always_ff @(posedge clk)
    begin
        if (s2_adv && in_valid)
        begin
            s2_reg.op       <= in_data.op;
            s2_reg.lin      <= lin;
            s2_reg.prod_ab  <= in_data.a * in_data.b;
            s2_reg.prod_shl <= in_data.a * $signed({1'b0, pow3(in_data.k)});
            s2_reg.prod_shr <= div_num * recip3(in_data.k);
            s2_k_reg        <= in_data.k;
        end
    end

    assign shr_quot = s2_reg.prod_shr[31:DivShift];

    always_comb
    begin
        case (s2_reg.op)
            OP_MUL:  raw = s2_reg.prod_ab;
            OP_SHL:  raw = {{2{s2_reg.prod_shl[17]}}, s2_reg.prod_shl};
            OP_SHR:  raw = $signed({8'd0, shr_quot}) - $signed({10'd0, base3(s2_k_reg)});
            default: raw = {{9{s2_reg.lin[10]}}, s2_reg.lin};
        endcase
    end

    assign lifted = raw + 20'sd132678;

    always_ff @(posedge clk)
    begin
        if (s3_adv && s2_vld_reg)
        begin
            s3_reg <= lifted[WrapWidth-1:0];
        end
    end

    assign out_valid = s3_vld_reg;
    assign out_data  = s3_reg;

`ifndef ASSERT_OFF
    // lifted value never exceeds 729 * 182 + 364 * 364
    a_lift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |-> (s3_reg <= 19'd265174))
        else $error("lifted value out of range");
`endif
endmodule

FILE: design/bttalu_mod729.sv
// stages 4 and 5: reduce modulo 729 by reciprocal multiply and map to -364..364
// depends on bttalu_pkg and bttalu_out_if
module bttalu_mod729
    import bttalu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lifted_t       in_data,
    bttalu_out_if.source  res
);
    logic                   s4_vld_reg;
    logic                   s4_vld_next;
    lifted_t                s4_w_reg;
    logic [QuotWidth-1:0]   s4_q_reg;
    logic                   s4_adv;

    logic                   s5_vld_reg;
    logic                   s5_vld_next;
    logic [FieldWidth-1:0]  s5_res_reg;
    logic                   s5_adv;

    logic [37:0]            quot_prod;
    logic [WrapWidth-1:0]   q_times;
    logic [WrapWidth-1:0]   rem_full;
    logic [FieldWidth-1:0]  rem;
    logic [FieldWidth-1:0]  folded;

    assign s5_adv      = !s5_vld_reg || res.ready;
    assign s4_adv      = !s4_vld_reg || s5_adv;
    assign in_ready    = s4_adv;
    assign s4_vld_next = s4_adv ? in_valid : s4_vld_reg;
    assign s5_vld_next = s5_adv ? s4_vld_reg : s5_vld_reg;

    assign quot_prod = in_data * 19'(ModRecip);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s4_vld_reg <= s4_vld_next;
            s5_vld_reg <= s5_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_adv && in_valid)
        begin
            s4_w_reg <= in_data;
            s4_q_reg <= quot_prod[ModShift+QuotWidth-1:ModShift];
        end
    end

    assign q_times  = {10'd0, s4_q_reg} * 19'(TryteMod);
    assign rem_full = s4_w_reg - q_times;
    assign rem      = rem_full[FieldWidth-1:0];
    assign folded   = (rem > 10'(TryteMax)) ? (rem - 10'(TryteMod)) : rem;

    always_ff @(posedge clk)
    begin
        if (s5_adv && s4_vld_reg)
        begin
            s5_res_reg <= folded;
        end
    end

    assign res.valid        = s5_vld_reg;
    assign res.result_value = s5_res_reg;

`ifndef ASSERT_OFF
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (s4_q_reg <= 9'd363))
        else $error("quotient out of range");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (rem_full < 19'd729))
        else $error("reciprocal reduction left remainder of 729 or more");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg |-> ($signed(s5_res_reg) >= -10'sd364 && $signed(s5_res_reg) <= 10'sd364))
        else $error("result outside tryte range");
`endif
endmodule

FILE: design/balanced_ternary_tryte_alu.sv
// pipeline: five register stages; a request accepted on req is registered in stage 1, then in
// stages 2, 3 and 4, and its result is held in stage 5, the output register seen on res
// throughput: one request per cycle while res is ready; the five stages advance independently,
// a bubble is squeezed out and a stalled res holds while earlier stages fill
// reset: rst_n clears all stage valid bits asynchronously; payload is not reset
// top level of the six-trit balanced-ternary alu; depends on bttalu_pkg, channel ifs, stage modules
module balanced_ternary_tryte_alu
    import bttalu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bttalu_in_if.sink     req,
    bttalu_out_if.source  res
);
    // stage 1 to stage 2: wrapped operands
    logic    opnd_valid;
    logic    opnd_ready;
    opnd_t   opnd_data;

    // stage 3 to stage 4: raw result lifted to a non-negative value
    logic    lift_valid;
    logic    lift_ready;
    lifted_t lift_data;

    // stage 1: out-of-range fields folded into -364..364
    bttalu_operand_stage u_operand (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (opnd_valid),
        .out_ready (opnd_ready),
        .out_data  (opnd_data)
    );

    // stages 2 and 3: multiplier, shift products, reciprocal divide for
    // right shifts, then per-op selection and lift by 729 * 182
    bttalu_op_unit u_ops (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (opnd_valid),
        .in_ready  (opnd_ready),
        .in_data   (opnd_data),
        .out_valid (lift_valid),
        .out_ready (lift_ready),
        .out_data  (lift_data)
    );

    // stages 4 and 5: modulo 729 and fold into the tryte range; stage 5 is
    // the output register seen on res
    bttalu_mod729 u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (lift_valid),
        .in_ready (lift_ready),
        .in_data  (lift_data),
        .res      (res)
    );
endmodule
